/* rtl/aln_pkg.sv */
// shared types and byte constants for the assembly line normalizer
// no dependencies

package aln_pkg;

  localparam logic [7:0] NL_BYTE       = 8'h0A;
  localparam logic [7:0] SPACE_BYTE    = 8'h20;
  localparam logic [7:0] TAB_BYTE      = 8'h09;
  localparam logic [7:0] COMMA_BYTE    = 8'h2C;
  localparam logic [7:0] COMMENT_RESET = 8'h3B;

  localparam int unsigned LINE_W = 16;

  typedef struct packed {
    logic              empty_input;
    logic              last_of_line;
    logic [LINE_W-1:0] line_number;
    logic [7:0]        out_char;
  } result_t;

  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

/* rtl/aln_core.sv */
// per-beat cleaning logic: line state, held character, comment register
// depends on aln_pkg

module aln_core #(
  parameter int unsigned LINE_NUMBER_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i,
  input  logic                 accept_i,
  input  logic                 kind_i,
  input  logic [7:0]           byte_i,
  output aln_pkg::push_t       push_o
);

  logic [7:0]                  comment_q;
  logic [7:0]                  held_char_q, held_char_d;
  logic                        held_valid_q, held_valid_d;
  logic                        space_q, space_d;
  logic                        in_comment_q, in_comment_d;
  logic [LINE_NUMBER_BITS-1:0] line_q, line_d;
  logic                        any_q, any_d;

  logic [LINE_NUMBER_BITS+aln_pkg::LINE_W-1:0] line_ext;
  logic [aln_pkg::LINE_W-1:0]                  line16;

  assign line_ext = {{aln_pkg::LINE_W{1'b0}}, line_q};
  assign line16   = line_ext[aln_pkg::LINE_W-1:0];

  always_comb begin
    held_char_d  = held_char_q;
    held_valid_d = held_valid_q;
    space_d      = space_q;
    in_comment_d = in_comment_q;
    line_d       = line_q;
    any_d        = any_q;
    push_o       = '0;
    if (accept_i) begin
      if (kind_i) begin
        if (held_valid_q) begin
          push_o.n               = 2'd1;
          push_o.r0.out_char     = held_char_q;
          push_o.r0.line_number  = line16;
          push_o.r0.last_of_line = 1'b1;
        end else if (!any_q) begin
          push_o.n              = 2'd1;
          push_o.r0.empty_input = 1'b1;
        end
        held_char_d  = '0;
        held_valid_d = 1'b0;
        space_d      = 1'b0;
        in_comment_d = 1'b0;
        line_d       = LINE_NUMBER_BITS'(1);
        any_d        = 1'b0;
      end else if (in_comment_q && byte_i != aln_pkg::NL_BYTE) begin
        in_comment_d = 1'b1;
      end else if (byte_i == aln_pkg::NL_BYTE) begin
        if (held_valid_q) begin
          push_o.n               = 2'd1;
          push_o.r0.out_char     = held_char_q;
          push_o.r0.line_number  = line16;
          push_o.r0.last_of_line = 1'b1;
        end
        held_char_d  = '0;
        held_valid_d = 1'b0;
        space_d      = 1'b0;
        in_comment_d = 1'b0;
        if (line_q != '1) begin
          line_d = line_q + LINE_NUMBER_BITS'(1);
        end
      end else if (byte_i == comment_q) begin
        in_comment_d = 1'b1;
      end else if (byte_i == aln_pkg::SPACE_BYTE || byte_i == aln_pkg::TAB_BYTE) begin
        if (held_valid_q && held_char_q != aln_pkg::COMMA_BYTE) begin
          space_d = 1'b1;
        end
      end else begin
        if (held_valid_q) begin
          push_o.n              = 2'd1;
          push_o.r0.out_char    = held_char_q;
          push_o.r0.line_number = line16;
          if (space_q) begin
            push_o.n              = 2'd2;
            push_o.r1.out_char    = aln_pkg::SPACE_BYTE;
            push_o.r1.line_number = line16;
          end
        end
        space_d      = 1'b0;
        held_char_d  = byte_i;
        held_valid_d = 1'b1;
        any_d        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      comment_q    <= aln_pkg::COMMENT_RESET;
      held_char_q  <= '0;
      held_valid_q <= 1'b0;
      space_q      <= 1'b0;
      in_comment_q <= 1'b0;
      line_q       <= LINE_NUMBER_BITS'(1);
      any_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        comment_q <= cfg_wdata_i;
      end
      held_char_q  <= held_char_d;
      held_valid_q <= held_valid_d;
      space_q      <= space_d;
      in_comment_q <= in_comment_d;
      line_q       <= line_d;
      any_q        <= any_d;
    end
  end

endmodule

/* rtl/aln_outq.sv */
// three-entry result queue, up to two pushes and one pop per cycle
// depends on aln_pkg

module aln_outq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  aln_pkg::push_t   push_i,
  input  logic             pop_ready_i,
  output logic             room_o,
  output logic             valid_o,
  output aln_pkg::result_t head_o
);

  localparam int unsigned Depth = 3;
  localparam int unsigned IdxW  = $clog2(Depth);

  aln_pkg::result_t ent_q [Depth];
  aln_pkg::result_t ent_d [Depth];
  logic [IdxW-1:0]  count_q, count_d;
  logic [IdxW-1:0]  base;
  logic             pop;

  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= IdxW'(1));
  assign head_o  = ent_q[0];
  assign pop     = valid_o && pop_ready_i;
  assign base    = count_q - IdxW'(pop);
  assign count_d = base + IdxW'(push_i.n);

  always_comb begin
    for (int i = 0; i < Depth; i++) begin
      ent_d[i] = ent_q[i];
    end
    if (pop) begin
      for (int i = 0; i < Depth - 1; i++) begin
        ent_d[i] = ent_q[i+1];
      end
    end
    for (int i = 0; i < Depth; i++) begin
      if (push_i.n != 2'd0 && base == IdxW'(i)) begin
        ent_d[i] = push_i.r0;
      end
      if (push_i.n == 2'd2 && base + IdxW'(1) == IdxW'(i)) begin
        ent_d[i] = push_i.r1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < Depth; i++) begin
      ent_q[i] <= ent_d[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

endmodule

/* rtl/assembly_line_normalizer.sv */
// Takes one source byte per beat and delivers cleaned characters tagged with their line
// number; one beat per cycle in while ready is high, one result per cycle out while
// m_axis_tready is high. The last character of each line is held until the line ends,
// so a beat gives zero, one or two results. Ready comes from the three-entry result
// queue: it is high while at most one result waits, so a steady stream runs at one beat
// per cycle, and a beat that yields two results (character plus collapsed space) leaves
// at least two results waiting and drops ready until at most one waits again. End of
// input (tuser high) flushes the held character, or reports empty input if no line was
// produced, and returns the block to its reset state except for the comment byte.
// depends on aln_pkg, aln_core, aln_outq

module assembly_line_normalizer #(
  parameter int unsigned LINE_NUMBER_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  logic [0:0]  s_axis_tuser,   // [0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [7:0] out_char, [23:8] line_number
  output logic        m_axis_tlast,
  output logic [0:0]  m_axis_tuser    // [0] empty_input
);

  aln_pkg::push_t   push;
  aln_pkg::result_t head;
  logic             accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  aln_core #(
    .LINE_NUMBER_BITS(LINE_NUMBER_BITS)
  ) u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .accept_i   (accept),
    .kind_i     (s_axis_tuser[0]),
    .byte_i     (s_axis_tdata),
    .push_o     (push)
  );

  aln_outq u_outq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .pop_ready_i(m_axis_tready),
    .room_o     (s_axis_tready),
    .valid_o    (m_axis_tvalid),
    .head_o     (head)
  );

  assign m_axis_tdata = {head.line_number, head.out_char};
  assign m_axis_tlast = head.last_of_line;
  assign m_axis_tuser = head.empty_input;

endmodule

/* rtl/aln_checker.sv */
// port-level checks for assembly_line_normalizer, bound to the top level
// no dependencies

module aln_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata,
  input logic        m_axis_tlast,
  input logic [0:0]  m_axis_tuser
);

  // empty-input beat carries nothing else
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata == 24'd0 && !m_axis_tlast)
    else $error("empty input beat with nonzero fields");

  // character beats always carry a line number
  a_line_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[23:8] != 16'd0)
    else $error("character beat with line number zero");

  // a line never ends in a space
  a_no_trailing_space: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[7:0] != 8'h20)
    else $error("line ends in a space");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast) && $stable(m_axis_tuser))
    else $error("stalled output beat changed");

endmodule

bind assembly_line_normalizer aln_checker u_aln_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tlast (m_axis_tlast),
  .m_axis_tuser (m_axis_tuser)
);
